@@ sv/swarp_pkg.sv @@
`default_nettype none

package swarp_pkg;

   localparam int PIXEL_BITS   = 32;
   localparam int WINDOW_DEPTH = 64;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int MAX_WIDTH    = 4096;
   localparam int ROW_LIMIT    = 4096;
   localparam int COL_BITS     = 12;
   localparam int DIM_BITS     = COL_BITS + 1;
   localparam int LAG          = 31;
   localparam int OFF_BITS     = $clog2(LAG + 1);
   localparam int SHIFT_BITS   = 6;
   localparam int ANGLE_BITS   = 9;
   localparam int ANGLE_FULL   = 360;
   localparam int PROD_BITS    = 16;
   localparam int RECIP_360    = 11651;   // ceil(2^22 / 360), exact for 16-bit dividends
   localparam int RECIP_SHIFT  = 22;
   localparam int QUOT_BITS    = 8;
   localparam int SINE_BITS    = 17;
   localparam int SINE_FRAC    = 16;

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_ROW_PHASE       = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_DEGREES_PER_ROW = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_WAVE_AMPLITUDE  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_WIDTH     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_HEIGHT    = 3'd4;

   localparam logic [6:0]          RESET_ROW_PHASE       = 7'd0;
   localparam logic [3:0]          RESET_DEGREES_PER_ROW = 4'd10;
   localparam logic [4:0]          RESET_WAVE_AMPLITUDE  = 5'd16;
   localparam logic [DIM_BITS-1:0] RESET_IMAGE_WIDTH     = 13'd640;
   localparam logic [DIM_BITS-1:0] RESET_IMAGE_HEIGHT    = 13'd480;

   // Quarter-wave sine, Q1.16, one entry per degree 0..90
   localparam logic [SINE_BITS-1:0] SINE_Q16 [0:90] = '{
      17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
      17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
      17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
      17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
      17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
      17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
      17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
      17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
      17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
      17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
      17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
      17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
      17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

   typedef struct packed {
      logic [6:0]          row_phase;
      logic [3:0]          degrees_per_row;
      logic [4:0]          wave_amplitude;
      logic [DIM_BITS-1:0] width;    // effective, 1..MAX_WIDTH
      logic [DIM_BITS-1:0] height;   // effective, 1..ROW_LIMIT
   } cfg_type;

   typedef struct packed {
      logic [COL_BITS-1:0]          first_col;
      logic [COL_BITS-1:0]          last_col;
      logic signed [SHIFT_BITS-1:0] shift;
      logic                         row_end;
      logic                         frame_end;
   } cmd_type;

   typedef struct packed {
      logic                  en;
      logic [WIN_AW-1:0]     addr;
      logic [PIXEL_BITS-1:0] src;
      logic [PIXEL_BITS-1:0] cnv;
   } wr_type;

   typedef struct packed {
      logic [1:0] count;
      logic       flush_pend;
   } qstat_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  row_done;
      logic                  frame_done;
   } res_type;

endpackage

`default_nettype wire

@@ sv/swarp_front.sv @@
`default_nettype none

module swarp_front
   import swarp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  cfg_wr,
   input  wire logic                  req_valid,
   input  wire logic [PIXEL_BITS-1:0] req_src,
   input  wire logic [PIXEL_BITS-1:0] req_cnv,
   output logic                       req_ready,
   input  wire qstat_type             qstat,
   output logic                       push_valid,
   output cmd_type                    push_cmd,
   output wr_type                     wr
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PROD  = 3'd1;
   localparam logic [2:0] ST_QUOT  = 3'd2;
   localparam logic [2:0] ST_REM   = 3'd3;
   localparam logic [2:0] ST_SINE  = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;

   logic [2:0]                   step_ff, step_in;
   logic [COL_BITS-1:0]          col_ff, col_in;
   logic [COL_BITS-1:0]          row_ff, row_in;
   logic [PROD_BITS-1:0]         x_ff, x_in;
   logic [QUOT_BITS-1:0]         q_ff, q_in;
   logic [ANGLE_BITS-1:0]        a_ff, a_in;
   logic [SINE_BITS-1:0]         t_ff, t_in;
   logic                         neg_ff, neg_in;
   logic signed [SHIFT_BITS-1:0] shift_ff, shift_in;

   logic                         busy, accept, last, frame_end, lag_ok;
   logic [DIM_BITS-1:0]          phase_sum;
   logic [DIM_BITS+3:0]          angle_prod;
   logic [PROD_BITS+13:0]        recip_prod;
   logic [PROD_BITS-1:0]         quot_360, rem;
   logic [ANGLE_BITS-1:0]        fold;
   logic [SINE_BITS+4:0]         scaled;
   logic [SHIFT_BITS-1:0]        mag;

   assign busy      = (step_ff != ST_IDLE);
   assign req_ready = !busy && (qstat.count <= 2'd1) && !qstat.flush_pend;
   assign accept    = req_valid && req_ready;

   assign last      = (({1'b0, col_ff} + DIM_BITS'(1)) >= cfg.width);
   assign frame_end = (({1'b0, row_ff} + DIM_BITS'(1)) >= cfg.height);
   assign lag_ok    = (col_ff >= COL_BITS'(LAG));

   assign push_valid         = accept && (last || lag_ok);
   assign push_cmd.first_col = lag_ok ? (col_ff - COL_BITS'(LAG)) : '0;
   assign push_cmd.last_col  = last ? col_ff : (col_ff - COL_BITS'(LAG));
   assign push_cmd.shift     = shift_ff;
   assign push_cmd.row_end   = last;
   assign push_cmd.frame_end = last && frame_end;

   assign wr.en   = accept;
   assign wr.addr = col_ff[WIN_AW-1:0];
   assign wr.src  = req_src;
   assign wr.cnv  = req_cnv;

   // row shift: angle = ((row + phase) * step) mod 360, then sine * amplitude
   assign phase_sum  = {1'b0, row_ff} + DIM_BITS'(cfg.row_phase);
   assign angle_prod = (DIM_BITS+4)'(phase_sum) * (DIM_BITS+4)'(cfg.degrees_per_row);
   assign recip_prod = (PROD_BITS+14)'(x_ff) * (PROD_BITS+14)'(RECIP_360);
   assign quot_360   = PROD_BITS'(q_ff) * PROD_BITS'(ANGLE_FULL);
   assign rem        = x_ff - quot_360;
   assign scaled     = (SINE_BITS+5)'(t_ff) * (SINE_BITS+5)'(cfg.wave_amplitude);
   assign mag        = SHIFT_BITS'(scaled >> SINE_FRAC);

   always_comb begin
      if (a_ff <= ANGLE_BITS'(90)) begin
         fold = a_ff;
      end else if (a_ff <= ANGLE_BITS'(180)) begin
         fold = ANGLE_BITS'(180) - a_ff;
      end else if (a_ff <= ANGLE_BITS'(270)) begin
         fold = a_ff - ANGLE_BITS'(180);
      end else begin
         fold = ANGLE_BITS'(ANGLE_FULL) - a_ff;
      end
   end

   always_comb begin
      step_in  = step_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      a_in     = a_ff;
      t_in     = t_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      case (step_ff)
         ST_IDLE: begin
            step_in = ST_IDLE;
         end
         ST_PROD: begin
            x_in    = angle_prod[PROD_BITS-1:0];
            step_in = ST_QUOT;
         end
         ST_QUOT: begin
            q_in    = recip_prod[RECIP_SHIFT +: QUOT_BITS];
            step_in = ST_REM;
         end
         ST_REM: begin
            a_in    = (rem >= PROD_BITS'(ANGLE_FULL)) ?
                      ANGLE_BITS'(rem - PROD_BITS'(ANGLE_FULL)) : ANGLE_BITS'(rem);
            step_in = ST_SINE;
         end
         ST_SINE: begin
            t_in    = SINE_Q16[fold[6:0]];
            neg_in  = (a_ff > ANGLE_BITS'(180));
            step_in = ST_SCALE;
         end
         ST_SCALE: begin
            shift_in = neg_ff ? $signed(SHIFT_BITS'(0) - mag) : $signed(mag);
            step_in  = ST_IDLE;
         end
         default: begin
            step_in = ST_IDLE;
         end
      endcase
      if (cfg_wr || (accept && last)) begin
         step_in = ST_PROD;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = frame_end ? '0 : (row_ff + COL_BITS'(1));
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_PROD;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         step_ff <= step_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      q_ff     <= q_in;
      a_ff     <= a_in;
      t_ff     <= t_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
   end

`ifndef SYNTHESIS
   a_row_end_recomputes: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (step_ff == ST_PROD))
      else $error("row end did not start shift recompute");
`endif

endmodule

`default_nettype wire

@@ sv/swarp_queue.sv @@
`default_nettype none

module swarp_queue
   import swarp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd,
   output qstat_type    qstat
);

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       flush_pend_ff, flush_pend_in;

   assign head_valid       = (count_ff != 2'd0);
   assign head_cmd         = ent_ff[rd_ptr_ff];
   assign qstat.count      = count_ff;
   assign qstat.flush_pend = flush_pend_ff;

   always_comb begin
      wr_ptr_in     = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in      = count_ff + 2'(push_valid) - 2'(pop);
      flush_pend_in = flush_pend_ff;
      if (pop && head_cmd.row_end) begin
         flush_pend_in = 1'b0;
      end
      if (push_valid && push_cmd.row_end) begin
         flush_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
         flush_pend_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         flush_pend_ff <= flush_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != 2'd2))
      else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("command queue underflow");
`endif

endmodule

`default_nettype wire

@@ sv/swarp_back.sv @@
`default_nettype none

module swarp_back
   import swarp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wr_type              wr,
   input  wire logic [DIM_BITS-1:0] width,
   input  wire logic                head_valid,
   input  wire cmd_type             head_cmd,
   output logic                     pop,
   output logic                     res_valid,
   input  wire logic                res_ready,
   output res_type                  res
);

   logic [PIXEL_BITS-1:0]  src_win_ff [WINDOW_DEPTH];
   logic [PIXEL_BITS-1:0]  cnv_win_ff [WINDOW_DEPTH];
   logic [PIXEL_BITS-1:0]  src_rd_ff, cnv_rd_ff;
   logic                   sel_ff, row_end_ff, frame_end_ff;
   logic                   rd_valid_ff;

   logic [OFF_BITS-1:0]    off_ff, off_in;
   res_type                ob_ff [2];
   logic                   ob_wr_ff, ob_rd_ff;
   logic [1:0]             ob_cnt_ff, ob_cnt_in;

   logic [COL_BITS-1:0]    col;
   logic signed [COL_BITS+1:0] src_col;
   logic                   in_row, at_end, issue, out_pop;
   logic [2:0]             occ;
   res_type                rd_res;

   // output column and the source column it pulls from
   assign col     = head_cmd.first_col + COL_BITS'(off_ff);
   assign src_col = $signed({2'b00, col}) - (COL_BITS+2)'(head_cmd.shift);
   assign in_row  = !src_col[COL_BITS+1] && (src_col[COL_BITS:0] < width);
   assign at_end  = (col == head_cmd.last_col);

   assign out_pop = res_valid && res_ready;
   assign occ     = 3'(ob_cnt_ff) + 3'(rd_valid_ff) - 3'(out_pop);
   assign issue   = head_valid && (occ <= 3'd1);
   assign pop     = issue && at_end;
   assign off_in  = issue ? (at_end ? '0 : (off_ff + OFF_BITS'(1))) : off_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         src_win_ff[wr.addr] <= wr.src;
         cnv_win_ff[wr.addr] <= wr.cnv;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         src_rd_ff    <= src_win_ff[src_col[WIN_AW-1:0]];
         cnv_rd_ff    <= cnv_win_ff[col[WIN_AW-1:0]];
         sel_ff       <= in_row;
         row_end_ff   <= head_cmd.row_end && at_end;
         frame_end_ff <= head_cmd.frame_end && at_end;
      end
   end

   assign rd_res.pixel      = sel_ff ? src_rd_ff : cnv_rd_ff;
   assign rd_res.row_done   = row_end_ff;
   assign rd_res.frame_done = frame_end_ff;

   assign res_valid = (ob_cnt_ff != 2'd0);
   assign res       = ob_ff[ob_rd_ff];
   assign ob_cnt_in = ob_cnt_ff + 2'(rd_valid_ff) - 2'(out_pop);

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         ob_ff[ob_wr_ff] <= rd_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff      <= '0;
         rd_valid_ff <= 1'b0;
         ob_wr_ff    <= 1'b0;
         ob_rd_ff    <= 1'b0;
         ob_cnt_ff   <= 2'd0;
      end else begin
         off_ff      <= off_in;
         rd_valid_ff <= issue;
         ob_wr_ff    <= rd_valid_ff ? !ob_wr_ff : ob_wr_ff;
         ob_rd_ff    <= out_pop ? !ob_rd_ff : ob_rd_ff;
         ob_cnt_ff   <= ob_cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_ob_room: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ((ob_cnt_ff != 2'd2) || out_pop))
      else $error("result buffer overflow");
`endif

endmodule

`default_nettype wire

@@ sv/sine_row_displacement_warp_core.sv @@
`default_nettype none

// Sine row displacement warp. Takes a raster-order stream of (source, canvas)
// pixel pairs and shifts row r sideways by
// trunc(sin(((r + row_phase) * degrees_per_row) mod 360 deg) * wave_amplitude);
// an output column whose source column falls outside the row keeps the canvas
// pixel. Results trail inputs by 31 columns; the last pixel of a row flushes
// the remainder of that row (up to 32 results), with rsp_tlast on the row's last
// result and rsp_tuser on the picture's last result. Rate: one transaction per
// cycle inside a row unless rsp_tready stalls, paced by the back end's single
// window read per result. At each row end the input holds tready low until the
// flush has been read out of the window and the next row's shift is computed
// (PROD, QUOT, REM, SINE, SCALE; overlapping); a register write or reset also starts it.
// The user must write registers only while the block is idle; it does not enforce this.

module sine_row_displacement_warp_core
   import swarp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,   // [31:0] source_pixel, [63:32] canvas_pixel
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [PIXEL_BITS-1:0]      rsp_tdata,   // [31:0] out_pixel
   output logic                       rsp_tlast,   // row_done
   output logic                       rsp_tuser,   // [0] frame_done
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_AW-1:0]     csr_addr,
   input  wire logic [DIM_BITS-1:0]   csr_wdata
);

   logic [6:0]          row_phase_ff;
   logic [3:0]          degrees_per_row_ff;
   logic [4:0]          wave_amplitude_ff;
   logic [DIM_BITS-1:0] image_width_ff;
   logic [DIM_BITS-1:0] image_height_ff;

   cfg_type   cfg;
   logic      cfg_wr;
   logic      push_valid, pop, head_valid;
   cmd_type   push_cmd, head_cmd;
   qstat_type qstat;
   wr_type    wr;
   res_type   res;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_phase_ff       <= RESET_ROW_PHASE;
         degrees_per_row_ff <= RESET_DEGREES_PER_ROW;
         wave_amplitude_ff  <= RESET_WAVE_AMPLITUDE;
         image_width_ff     <= RESET_IMAGE_WIDTH;
         image_height_ff    <= RESET_IMAGE_HEIGHT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ROW_PHASE:       row_phase_ff       <= csr_wdata[6:0];
            CSR_DEGREES_PER_ROW: degrees_per_row_ff <= csr_wdata[3:0];
            CSR_WAVE_AMPLITUDE:  wave_amplitude_ff  <= csr_wdata[4:0];
            CSR_IMAGE_WIDTH:     image_width_ff     <= csr_wdata;
            CSR_IMAGE_HEIGHT:    image_height_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // writes to unmapped indexes change nothing and trigger no recompute
   always_comb begin
      case (csr_addr)
         CSR_ROW_PHASE, CSR_DEGREES_PER_ROW, CSR_WAVE_AMPLITUDE,
         CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT: cfg_wr = csr_we;
         default: cfg_wr = 1'b0;
      endcase
   end

   // zero size acts as 1, oversize clamps to the limits
   always_comb begin
      cfg.row_phase       = row_phase_ff;
      cfg.degrees_per_row = degrees_per_row_ff;
      cfg.wave_amplitude  = wave_amplitude_ff;
      if (image_width_ff == '0) begin
         cfg.width = DIM_BITS'(1);
      end else if (image_width_ff > DIM_BITS'(MAX_WIDTH)) begin
         cfg.width = DIM_BITS'(MAX_WIDTH);
      end else begin
         cfg.width = image_width_ff;
      end
      if (image_height_ff == '0) begin
         cfg.height = DIM_BITS'(1);
      end else if (image_height_ff > DIM_BITS'(ROW_LIMIT)) begin
         cfg.height = DIM_BITS'(ROW_LIMIT);
      end else begin
         cfg.height = image_height_ff;
      end
   end

   // front end: column/row tracking, window writes, per-row shift
   swarp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_wr     (cfg_wr),
      .req_valid  (req_tvalid),
      .req_src    (req_tdata[PIXEL_BITS-1:0]),
      .req_cnv    (req_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
      .req_ready  (req_tready),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .wr         (wr)
   );

   // two-deep command queue; also tracks an outstanding row flush
   swarp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .qstat      (qstat)
   );

   // back end: windows, one read per result, two-entry result buffer
   swarp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .width      (cfg.width),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   assign rsp_tdata = res.pixel;
   assign rsp_tlast = res.row_done;
   assign rsp_tuser = res.frame_done;

endmodule

`default_nettype wire
